// ===== hw/rtl/sst_pkg.sv =====
// ============================================================================
// sst_pkg
// Shared types and codes for the sorted set table: operation codes, result
// status codes and the packed result item.
// ============================================================================
package sst_pkg;

    // Operation codes carried in the input transaction
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOT_DONE = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;

    // Field widths fixed by the stream format
    localparam int OPCODE_W = 2;
    localparam int IN_KEY_W = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Result item, packed with status in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic                member;
        logic [STATUS_W-1:0] status;
    } res_t;

endpackage

// ===== hw/rtl/sst_key_ram.sv =====
// ============================================================================
// sst_key_ram
// Single write port, single read port key store with a registered read.
// ============================================================================
module sst_key_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write the addressed entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read data
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/sst_ctrl.sv =====
// ============================================================================
// sst_ctrl
// Sequencer for the sorted set: scans the key store for the lower bound,
// shifts entries up or down to open or close a slot, writes the new key and
// keeps the key count.
// ============================================================================
module sst_ctrl #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32,
    parameter int AW        = 4,
    parameter int CW        = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Operation request
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_opcode,
    input  logic [KEY_WIDTH-1:0] in_key,
    // Result hand-off
    output logic                 res_valid,
    input  logic                 res_ready,
    output sst_pkg::res_t        res,
    // Key store port
    output logic                 ram_we,
    output logic [AW-1:0]        ram_waddr,
    output logic [KEY_WIDTH-1:0] ram_wdata,
    output logic [AW-1:0]        ram_raddr,
    input  logic [KEY_WIDTH-1:0] ram_rdata
);
    import sst_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHUP   = 3'd3;
    localparam logic [2:0] S_SHDN   = 3'd4;
    localparam logic [2:0] S_WRKEY  = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    logic [2:0]           state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic                 found_reg, found_next;
    logic [CW-1:0]        count_reg, count_next;
    res_t                 res_reg, res_next;

    logic [CW-1:0]        idx_w;
    logic [CW-1:0]        idx_inc_w;

    assign idx_w     = CW'(idx_reg);
    assign idx_inc_w = idx_w + ONE_C;

    // Sequence one operation
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        found_next = found_reg;
        count_next = count_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = key_reg;
        ram_raddr  = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next  = in_opcode;
                    key_next = in_key;
                    idx_next = '0;
                    if (count_reg == '0) begin
                        pos_next   = '0;
                        found_next = 1'b0;
                        state_next = S_DECIDE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end

            // Walk up the store until an entry not below the key or the end of the held keys
            S_SCAN: begin
                if (ram_rdata >= key_reg) begin
                    pos_next   = idx_w;
                    found_next = (ram_rdata == key_reg);
                    state_next = S_DECIDE;
                end else if (idx_inc_w == count_reg) begin
                    pos_next   = count_reg;
                    found_next = 1'b0;
                    state_next = S_DECIDE;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    ram_raddr  = idx_reg + AW'(1);
                end
            end

            S_DECIDE: begin
                state_next = S_RESULT;
                case (op_reg)
                    OP_INSERT: begin
                        if (found_reg) begin
                            res_next.status = ST_NOT_DONE;
                            res_next.member = 1'b1;
                        end else if (count_reg == CAP_C) begin
                            res_next.status = ST_ERROR;
                            res_next.member = 1'b0;
                        end else if (pos_reg == count_reg) begin
                            state_next = S_WRKEY;
                        end else begin
                            // Start the upward shift from the top entry
                            idx_next   = AW'(count_reg - ONE_C);
                            ram_raddr  = AW'(count_reg - ONE_C);
                            state_next = S_SHUP;
                        end
                    end
                    OP_REMOVE: begin
                        res_next.member = 1'b0;
                        if (count_reg == '0) begin
                            res_next.status = ST_ERROR;
                        end else if (!found_reg) begin
                            res_next.status = ST_NOT_DONE;
                        end else if (pos_reg + ONE_C == count_reg) begin
                            res_next.status = ST_DONE;
                            count_next      = count_reg - ONE_C;
                        end else begin
                            // Start the downward shift just above the gap
                            idx_next   = AW'(pos_reg + ONE_C);
                            ram_raddr  = AW'(pos_reg + ONE_C);
                            state_next = S_SHDN;
                        end
                    end
                    OP_LOOKUP: begin
                        res_next.status = found_reg ? ST_DONE : ST_NOT_DONE;
                        res_next.member = found_reg;
                    end
                    default: begin
                        res_next.status = ST_ERROR;
                        res_next.member = found_reg;
                    end
                endcase
            end

            // Move each entry from pos up by one, highest first
            S_SHUP: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg + AW'(1);
                ram_wdata = ram_rdata;
                if (idx_w == pos_reg) begin
                    state_next = S_WRKEY;
                end else begin
                    idx_next  = idx_reg - AW'(1);
                    ram_raddr = idx_reg - AW'(1);
                end
            end

            // Move each entry above the gap down by one
            S_SHDN: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg - AW'(1);
                ram_wdata = ram_rdata;
                if (idx_inc_w == count_reg) begin
                    count_next      = count_reg - ONE_C;
                    res_next.status = ST_DONE;
                    res_next.member = 1'b0;
                    state_next      = S_RESULT;
                end else begin
                    idx_next  = idx_reg + AW'(1);
                    ram_raddr = idx_reg + AW'(1);
                end
            end

            // Drop the new key into the opened slot
            S_WRKEY: begin
                ram_we          = 1'b1;
                ram_waddr       = AW'(pos_reg);
                ram_wdata       = key_reg;
                count_next      = count_reg + ONE_C;
                res_next.status = ST_DONE;
                res_next.member = 1'b1;
                state_next      = S_RESULT;
            end

            S_RESULT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        res_next.count = COUNT_W'(count_next);
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Operation payload
    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        res_reg   <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign res       = res_reg;

endmodule

// ===== hw/rtl/sorted_set_table.sv =====
// Timing: scan and shift move one entry per cycle; one transaction is handled
//   at a time, and the next input is taken in the cycle after the result moves
//   to the output register.
// Reset: aresetn low on a clock edge empties the set and drops any result;
//   the key store itself is not cleared and needs no clearing pass.
// ============================================================================
// sorted_set_table
// Ordered set of distinct keys held in a synchronous key store, with insert,
// remove and lookup, one result transaction per input transaction.
// ============================================================================
module sorted_set_table #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // opcode[1:0], key[33:2], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // status[1:0], member[2], count[7:3]
);
    import sst_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [KEY_WIDTH-1:0] key_w;
    logic                 res_valid;
    logic                 res_ready;
    res_t                 res;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [KEY_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [KEY_WIDTH-1:0] ram_rdata;
    logic                 out_valid_reg;
    res_t                 out_reg;

    // Keep the used key bits
    assign key_w = KEY_WIDTH'(s_axis_tdata[OPCODE_W +: IN_KEY_W]);

    sst_ctrl #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_opcode (s_axis_tdata[OPCODE_W-1:0]),
        .in_key    (key_w),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    sst_key_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_WIDTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Take a result when the output slot is free or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    // Hold the result transaction until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule
